@@ rtl/mte_pkg.sv @@
package mte_pkg;

  localparam int DIM = 4;
  localparam int ROW_W = 2;
  localparam int ELEM_W = 32;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W = 40;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(DIM - 1);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_COMPOSE = 2'd1,
    KIND_VECTOR  = 2'd2,
    KIND_POINT   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ROW_W-1:0]  row;
    elem_t             elem_0;
    elem_t             elem_1;
    elem_t             elem_2;
    elem_t             elem_3;
  } cmd_t;

  typedef struct packed {
    elem_t out_0;
    elem_t out_1;
    elem_t out_2;
    elem_t out_3;
    logic  saturated;
  } res_t;

  // Per-lane pipeline strobes issued by the top-level control.
  typedef struct packed {
    logic row_load;
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic acc_en;
    logic commit;
  } lane_ctrl_t;

  // Saturate a 41-bit accumulator sum to 40 bits.
  function automatic acc_t sat_acc(input logic signed [ACC_W:0] x);
    acc_t r;
    if (x[ACC_W] == x[ACC_W-1]) begin
      r = x[ACC_W-1:0];
    end else if (x[ACC_W]) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate a 40-bit accumulator to a 32-bit matrix element.
  function automatic elem_t sat_elem(input acc_t x);
    elem_t r;
    if ((&x[ACC_W-1:ELEM_W-1]) || !(|x[ACC_W-1:ELEM_W-1])) begin
      r = x[ELEM_W-1:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ELEM_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/mte_lane.sv @@
module mte_lane #(
  parameter int FRAC_BITS = 16,
  parameter int LANE = 0
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  mte_pkg::cmd_t                                  cmd,
  input  mte_pkg::lane_ctrl_t                            ctrl,
  output logic signed [mte_pkg::PROD_W-FRAC_BITS+1:0]    sum
);

  localparam int DIM = mte_pkg::DIM;
  localparam int RW = mte_pkg::PROD_W - FRAC_BITS;
  localparam int SUM_W = RW + 2;
  localparam int ACC_W = mte_pkg::ACC_W;
  localparam mte_pkg::elem_t ONE = mte_pkg::elem_t'(64'd1 << FRAC_BITS);

  // This lane owns one row of the matrix and the matching row of compose sums.
  mte_pkg::elem_t m [DIM];
  mte_pkg::acc_t  acc [DIM];

  mte_pkg::elem_t e [DIM];
  mte_pkg::elem_t op_a [DIM];
  mte_pkg::elem_t op_b [DIM];
  logic signed [mte_pkg::PROD_W-1:0] prod [DIM];
  logic signed [RW-1:0] rnd_next [DIM];
  logic signed [RW-1:0] rnd [DIM];
  mte_pkg::acc_t  rnd_clamp [DIM];
  mte_pkg::acc_t  acc_new [DIM];
  logic signed [SUM_W-1:0] sum_next;

  assign e[0] = cmd.elem_0;
  assign e[1] = cmd.elem_1;
  assign e[2] = cmd.elem_2;
  assign e[3] = cmd.elem_3;

  // A compose row pairs column "row" of this matrix row with every element.
  // A point feeds 1.0 into the last multiplier so it yields the translation.
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      op_a[j] = (cmd.kind == mte_pkg::KIND_COMPOSE) ? m[cmd.row] : m[j];
      op_b[j] = e[j];
    end
    if (cmd.kind == mte_pkg::KIND_POINT) begin
      op_b[DIM-1] = ONE;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIM; j++) begin
      if (ctrl.s1_load) begin
        prod[j] <= op_a[j] * op_b[j];
      end
    end
  end

  // Round to nearest, ties upward: floor shift plus the first dropped bit.
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      rnd_next[j] = $signed(prod[j][mte_pkg::PROD_W-1:FRAC_BITS])
                  + $signed({1'b0, prod[j][FRAC_BITS-1]});
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIM; j++) begin
      if (ctrl.s2_load) begin
        rnd[j] <= rnd_next[j];
      end
    end
  end

  assign sum_next = SUM_W'(rnd[0]) + SUM_W'(rnd[1]) + SUM_W'(rnd[2]) + SUM_W'(rnd[3]);

  always_ff @(posedge clk) begin
    if (ctrl.s3_load) begin
      sum <= sum_next;
    end
  end

  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      if ((&rnd[j][RW-1:ACC_W-1]) || !(|rnd[j][RW-1:ACC_W-1])) begin
        rnd_clamp[j] = rnd[j][ACC_W-1:0];
      end else if (rnd[j][RW-1]) begin
        rnd_clamp[j] = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
        rnd_clamp[j] = {1'b0, {(ACC_W-1){1'b1}}};
      end
      acc_new[j] = mte_pkg::sat_acc({acc[j][ACC_W-1], acc[j]}
                                    + {rnd_clamp[j][ACC_W-1], rnd_clamp[j]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DIM; j++) begin
        m[j]   <= (j == LANE) ? ONE : '0;
        acc[j] <= '0;
      end
    end else begin
      for (int j = 0; j < DIM; j++) begin
        if (ctrl.row_load) begin
          m[j] <= e[j];
        end
        if (ctrl.commit) begin
          m[j] <= mte_pkg::sat_elem(acc_new[j]);
        end
        if (ctrl.acc_en) begin
          acc[j] <= ctrl.commit ? '0 : acc_new[j];
        end
      end
    end
  end

endmodule

@@ rtl/mte_merge.sv @@
module mte_merge #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         in_valid,
  output logic                                         take,
  input  logic signed [mte_pkg::PROD_W-FRAC_BITS+1:0]  sums [mte_pkg::DIM],
  input  logic                                         point,
  input  mte_pkg::elem_t                               w,
  output logic                                         res_valid,
  input  logic                                         res_stall,
  output mte_pkg::res_t                                res
);

  localparam int DIM = mte_pkg::DIM;
  localparam int SUM_W = mte_pkg::PROD_W - FRAC_BITS + 2;
  localparam int EW = mte_pkg::ELEM_W;

  mte_pkg::elem_t clamped [DIM];
  logic [DIM-1:0] sat;
  mte_pkg::res_t  res_next;

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      sat[i] = !((&sums[i][SUM_W-1:EW-1]) || !(|sums[i][SUM_W-1:EW-1]));
      if (!sat[i]) begin
        clamped[i] = sums[i][EW-1:0];
      end else if (sums[i][SUM_W-1]) begin
        clamped[i] = {1'b1, {(EW-1){1'b0}}};
      end else begin
        clamped[i] = {1'b0, {(EW-1){1'b1}}};
      end
    end
    res_next.out_0 = clamped[0];
    res_next.out_1 = clamped[1];
    res_next.out_2 = clamped[2];
    res_next.out_3 = point ? w : clamped[3];
    // A point's fourth lane is not a result, so its clamp does not count.
    res_next.saturated = sat[0] | sat[1] | sat[2] | (sat[3] & !point);
  end

  assign take = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= (in_valid && take) || (res_valid && res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && take) begin
      res <= res_next;
    end
  end

endmodule

@@ rtl/mat4_transform_engine.sv @@
// A transform item passes the product, round and sum registers into the result on res.
// Throughput: one item per cycle while res is not stalled; after a compose item for the last
// row, cmd stalls while that row moves through the multiply and round stages to the matrix
// write, and longer when a transform ahead of it waits on a stalled res.
// A load item takes effect at its accepting edge and produces no result.
// Reset (rst, synchronous): matrix to identity, compose sums to zero, pipeline empty.
module mat4_transform_engine #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  mte_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output mte_pkg::res_t  res
);

  localparam int DIM = mte_pkg::DIM;
  localparam int SUM_W = mte_pkg::PROD_W - FRAC_BITS + 2;

  // Pipeline: stage 1 holds the sixteen products (four per row lane), stage 2
  // the rounded products, where compose items update the accumulators and
  // leave the pipe, stage 3 the per-row sums of a transform. The merge stage
  // clamps the four sums into the result register and raises the flag.

  logic s1_valid, s2_valid, s3_valid;
  mte_pkg::kind_t s1_kind, s2_kind;
  logic [mte_pkg::ROW_W-1:0] s1_row, s2_row;
  mte_pkg::elem_t s1_w, s2_w, s3_w;
  logic s3_point;

  logic accept, accept_op;
  logic take, s3_free, s2_adv, s2_free, s1_adv, s1_free;
  logic s1_commit, s2_commit, s2_compose;
  logic hazard;

  mte_pkg::lane_ctrl_t lane_ctrl [DIM];
  logic signed [SUM_W-1:0] lane_sum [DIM];

  assign s1_commit  = (s1_kind == mte_pkg::KIND_COMPOSE) && (s1_row == mte_pkg::LAST_ROW);
  assign s2_compose = (s2_kind == mte_pkg::KIND_COMPOSE);
  assign s2_commit  = s2_compose && (s2_row == mte_pkg::LAST_ROW);

  // Stages advance whenever the next one is empty or moving, so items keep
  // flowing in while a finished result waits on the output.
  assign s3_free = !s3_valid || take;
  assign s2_adv  = s2_valid && (s2_compose || s3_free);
  assign s2_free = !s2_valid || s2_adv;
  assign s1_adv  = s1_valid && s2_free;
  assign s1_free = !s1_valid || s1_adv;

  // A last-row compose rewrites the matrix when it leaves stage 2. Nothing
  // may read the matrix until that write has landed.
  assign hazard    = (s1_valid && s1_commit) || (s2_valid && s2_commit);
  assign cmd_stall = !s1_free || hazard;
  assign accept    = cmd_valid && !cmd_stall;
  assign accept_op = accept && (cmd.kind != mte_pkg::KIND_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept_op || (s1_valid && !s1_adv);
      s2_valid <= s1_adv || (s2_valid && !s2_adv);
      s3_valid <= (s2_adv && !s2_compose) || (s3_valid && !take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept_op) begin
      s1_kind <= cmd.kind;
      s1_row  <= cmd.row;
      s1_w    <= cmd.elem_3;
    end
    if (s1_adv) begin
      s2_kind <= s1_kind;
      s2_row  <= s1_row;
      s2_w    <= s1_w;
    end
    if (s2_adv && !s2_compose) begin
      s3_point <= (s2_kind == mte_pkg::KIND_POINT);
      s3_w     <= s2_w;
    end
  end

  for (genvar i = 0; i < DIM; i++) begin : g_lane
    always_comb begin
      lane_ctrl[i].row_load = accept && (cmd.kind == mte_pkg::KIND_LOAD)
                              && (cmd.row == mte_pkg::ROW_W'(i));
      lane_ctrl[i].s1_load  = accept_op;
      lane_ctrl[i].s2_load  = s1_adv;
      lane_ctrl[i].s3_load  = s2_adv && !s2_compose;
      lane_ctrl[i].acc_en   = s2_adv && s2_compose;
      lane_ctrl[i].commit   = s2_adv && s2_commit;
    end

    mte_lane #(
      .FRAC_BITS (FRAC_BITS),
      .LANE      (i)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .ctrl (lane_ctrl[i]),
      .sum  (lane_sum[i])
    );
  end

  mte_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .take      (take),
    .sums      (lane_sum),
    .point     (s3_point),
    .w         (s3_w),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // A committing compose has no item behind it in stage 1.
  a_commit_alone: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_commit) |-> !s1_valid)
    else $error("item entered behind a committing compose");

  // Loads never occupy the pipeline.
  a_load_bypass: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == mte_pkg::KIND_LOAD) |=> !s1_valid)
    else $error("load item entered the pipeline");

  // A transform handed to the merge stage is presented on the next cycle.
  a_merge_handoff: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && take) |=> res_valid)
    else $error("result lost at merge stage");

endmodule

@@ tb/mat4_transform_engine_tb.sv @@
`timescale 1ns / 1ps

module mat4_transform_engine_tb;

  localparam int FRAC = 16;
  localparam int RAND_ITEMS = 700;
  localparam int DIM = mte_pkg::DIM;
  localparam int ROW_W = mte_pkg::ROW_W;
  localparam int ELEM_W = mte_pkg::ELEM_W;
  localparam int ACC_W = mte_pkg::ACC_W;

  // Handy Q16.16 values used by the directed table and the random values.
  localparam mte_pkg::elem_t EMAX = 32'sh7fff_ffff;
  localparam mte_pkg::elem_t EMIN = 32'sh8000_0000;
  localparam mte_pkg::elem_t ONE = 32'sh0001_0000;
  localparam mte_pkg::elem_t TWO = 32'sh0002_0000;
  localparam mte_pkg::elem_t HALF = 32'sh0000_8000;

  // One row of the directed table. When has_want is set, the expected
  // result is typed in by hand and used instead of the predicted one.
  typedef struct {
    mte_pkg::cmd_t c;
    bit            has_want;
    mte_pkg::res_t want;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  mte_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  mte_pkg::res_t res;

  // Shadow copy of the block's state: the transform matrix and the bank of
  // compose accumulators, both row-major.
  mte_pkg::elem_t xform_m[DIM][DIM];
  longint comp_sum[DIM][DIM];

  mte_pkg::res_t pending_xforms[$];
  step_t directed_steps[$];
  int mismatches = 0;
  int cmds_sent = 0;
  bit no_idle = 1'b0;

  mat4_transform_engine #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A Q16.16 product rounded to nearest, with ties going toward +infinity.
  function automatic longint qmul(input mte_pkg::elem_t a, input mte_pkg::elem_t b);
    longint p;
    p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  // Saturate to a signed range of the given width; hit is set on a clamp.
  function automatic longint clamp_to(input longint x, input int bits, inout bit hit);
    longint hi;
    longint lo;
    longint y;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    y = x;
    if (x > hi) begin
      hit = 1'b1;
      y = hi;
    end else if (x < lo) begin
      hit = 1'b1;
      y = lo;
    end
    return y;
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        xform_m[i][j] = (i == j) ? ONE : '0;
        comp_sum[i][j] = 0;
      end
    end
  endfunction

  // Applies one accepted item to the shadow state. Returns 1 when the item
  // produces a result, which is then left in r.
  function automatic bit apply_cmd(input mte_pkg::cmd_t c, output mte_pkg::res_t r);
    mte_pkg::elem_t e[DIM];
    longint v[DIM];
    longint acc;
    longint p;
    bit sat;
    bit dropped;
    bit emits;
    int k;
    e[0] = c.elem_0;
    e[1] = c.elem_1;
    e[2] = c.elem_2;
    e[3] = c.elem_3;
    k = int'(c.row);
    sat = 1'b0;
    dropped = 1'b0;
    emits = 1'b0;
    r = '0;
    case (c.kind)
      mte_pkg::KIND_LOAD: begin
        for (int j = 0; j < DIM; j++) xform_m[k][j] = e[j];
      end
      mte_pkg::KIND_COMPOSE: begin
        // Row k of the second matrix pairs with column k of the stored one.
        for (int i = 0; i < DIM; i++) begin
          for (int j = 0; j < DIM; j++) begin
            p = clamp_to(qmul(xform_m[i][k], e[j]), ACC_W, dropped);
            comp_sum[i][j] = clamp_to(comp_sum[i][j] + p, ACC_W, dropped);
          end
        end
        if (c.row == mte_pkg::LAST_ROW) begin
          for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
              acc = clamp_to(comp_sum[i][j], ELEM_W, dropped);
              xform_m[i][j] = acc[ELEM_W-1:0];
              comp_sum[i][j] = 0;
            end
          end
        end
      end
      mte_pkg::KIND_VECTOR: begin
        for (int i = 0; i < DIM; i++) begin
          acc = 0;
          for (int j = 0; j < DIM; j++) acc += qmul(xform_m[i][j], e[j]);
          v[i] = clamp_to(acc, ELEM_W, sat);
        end
        emits = 1'b1;
      end
      default: begin
        // A point adds the translation column; its w passes through.
        for (int i = 0; i < DIM - 1; i++) begin
          acc = longint'(xform_m[i][DIM-1]);
          for (int j = 0; j < DIM - 1; j++) acc += qmul(xform_m[i][j], e[j]);
          v[i] = clamp_to(acc, ELEM_W, sat);
        end
        v[DIM-1] = longint'(e[DIM-1]);
        emits = 1'b1;
      end
    endcase
    if (emits) begin
      r.out_0 = v[0][ELEM_W-1:0];
      r.out_1 = v[1][ELEM_W-1:0];
      r.out_2 = v[2][ELEM_W-1:0];
      r.out_3 = v[3][ELEM_W-1:0];
      r.saturated = sat;
    end
    return emits;
  endfunction

  function automatic mte_pkg::cmd_t mk_cmd(input mte_pkg::kind_t k,
                                           input logic [ROW_W-1:0] r,
                                           input mte_pkg::elem_t a, input mte_pkg::elem_t b,
                                           input mte_pkg::elem_t c, input mte_pkg::elem_t d);
    mte_pkg::cmd_t m;
    m.kind = k;
    m.row = r;
    m.elem_0 = a;
    m.elem_1 = b;
    m.elem_2 = c;
    m.elem_3 = d;
    return m;
  endfunction

  function automatic mte_pkg::res_t mk_res(input mte_pkg::elem_t a, input mte_pkg::elem_t b,
                                           input mte_pkg::elem_t c, input mte_pkg::elem_t d,
                                           input logic s);
    mte_pkg::res_t m;
    m.out_0 = a;
    m.out_1 = b;
    m.out_2 = c;
    m.out_3 = d;
    m.saturated = s;
    return m;
  endfunction

  function automatic void add_step(input mte_pkg::cmd_t c, input bit has_want,
                                   input mte_pkg::res_t want);
    step_t s;
    s.c = c;
    s.has_want = has_want;
    s.want = want;
    directed_steps.push_back(s);
  endfunction

  // Cycles that either side idles before its next item.
  function automatic int idle_draw();
    return no_idle ? 0 : int'($urandom_range(0, 6));
  endfunction

  // Tame values stay near the unit range so that composed matrices keep
  // producing results that are not all clamped.
  function automatic mte_pkg::elem_t rand_elem(input bit tame);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      case ($urandom_range(0, 5))
        0: return EMAX;
        1: return EMIN;
        2: return '0;
        3: return ONE;
        4: return -ONE;
        default: return HALF;
      endcase
    end
    if (tame) begin
      if (sel < 60) return mte_pkg::elem_t'($urandom_range(0, 32'h3ffff) - 32'h1ffff);
      return ((sel & 1) ? ONE : -ONE)
             + mte_pkg::elem_t'($urandom_range(0, 32'h3ff) - 32'h1ff);
    end
    if (sel < 40) return mte_pkg::elem_t'($urandom_range(0, 32'hfffff) - 32'h7ffff);
    return mte_pkg::elem_t'($urandom);
  endfunction

  function automatic mte_pkg::cmd_t rand_cmd(input mte_pkg::kind_t k,
                                             input logic [ROW_W-1:0] r, input bit tame);
    return mk_cmd(k, r, rand_elem(tame), rand_elem(tame), rand_elem(tame),
                  rand_elem(tame));
  endfunction

  function automatic void check_field(input string name, input logic [ELEM_W-1:0] want,
                                      input logic [ELEM_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Offers one item and waits for the block to take it. Valid is only
  // lowered when a gap is drawn, so a back-to-back item never sees valid
  // dropped and raised within one time step.
  task automatic send_cmd(input mte_pkg::cmd_t c, input bit has_want,
                          input mte_pkg::res_t want);
    int gap;
    mte_pkg::res_t r;
    gap = idle_draw();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    if (apply_cmd(c, r)) pending_xforms.push_back(has_want ? want : r);
    cmds_sent++;
  endtask

  task automatic send_rand(input mte_pkg::cmd_t c);
    send_cmd(c, 1'b0, '0);
  endtask

  // Receiving side: stalls for a drawn number of cycles, then takes the
  // next result and checks it against the oldest expectation.
  initial begin
    int wait_n;
    mte_pkg::res_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_n = idle_draw();
      if (wait_n > 0) begin
        res_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
        res_stall <= 1'b0;
      end
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      if (pending_xforms.size() == 0) begin
        mismatches++;
        $display("%0t: result with none pending, expected nothing, got %h", $time, res);
      end else begin
        want = pending_xforms.pop_front();
        check_field("out_0", want.out_0, res.out_0);
        check_field("out_1", want.out_1, res.out_1);
        check_field("out_2", want.out_2, res.out_2);
        check_field("out_3", want.out_3, res.out_3);
        check_field("saturated", ELEM_W'(want.saturated), ELEM_W'(res.saturated));
      end
    end
  end

  // Main stimulus: reset, the directed table, then random scenes.
  initial begin
    int pick;
    int burst;
    reset_shadow();

    // After reset the matrix is identity, so vectors and points come back
    // unchanged, including the range extremes and an arbitrary row field.
    add_step(mk_cmd(mte_pkg::KIND_VECTOR, 2'd0, ONE, TWO, -3 * ONE, HALF), 1'b1,
             mk_res(ONE, TWO, -3 * ONE, HALF, 1'b0));
    add_step(mk_cmd(mte_pkg::KIND_VECTOR, 2'd3, EMAX, EMIN, -1, 1), 1'b1,
             mk_res(EMAX, EMIN, -1, 1, 1'b0));
    add_step(mk_cmd(mte_pkg::KIND_POINT, 2'd2, 32'sh1234_5678, -7, 0, EMIN), 1'b1,
             mk_res(32'sh1234_5678, -7, 0, EMIN, 1'b0));
    // Scale by two: the extremes clamp and raise the flag.
    for (int i = 0; i < DIM; i++) begin
      add_step(mk_cmd(mte_pkg::KIND_LOAD, ROW_W'(i), (i == 0) ? TWO : '0,
                      (i == 1) ? TWO : '0, (i == 2) ? TWO : '0, (i == 3) ? TWO : '0),
               1'b0, '0);
    end
    add_step(mk_cmd(mte_pkg::KIND_VECTOR, 2'd1, EMAX, EMIN, ONE, 0), 1'b1,
             mk_res(EMAX, EMIN, TWO, 0, 1'b1));
    add_step(mk_cmd(mte_pkg::KIND_POINT, 2'd0, ONE, -ONE, 32'sh4000_0000, 7), 1'b1,
             mk_res(TWO, -TWO, EMAX, 7, 1'b1));
    // Translation at the extremes: adding it to a point overflows both ways.
    add_step(mk_cmd(mte_pkg::KIND_LOAD, 2'd0, ONE, 0, 0, EMAX), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_LOAD, 2'd1, 0, ONE, 0, EMIN), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_LOAD, 2'd2, 0, 0, ONE, 5), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_LOAD, 2'd3, 0, 0, 0, ONE), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_POINT, 2'd3, 1, -1, 0, 3), 1'b1,
             mk_res(EMAX, EMIN, 5, 3, 1'b1));
    add_step(mk_cmd(mte_pkg::KIND_POINT, 2'd1, 0, 0, 0, 0), 1'b1,
             mk_res(EMAX, EMIN, 5, 0, 1'b0));
    add_step(mk_cmd(mte_pkg::KIND_VECTOR, 2'd2, ONE, ONE, ONE, ONE), 1'b0, '0);
    // Compose rows out of order, a load in the middle, a repeated row, and
    // products big enough to saturate the accumulators before the commit.
    add_step(mk_cmd(mte_pkg::KIND_COMPOSE, 2'd2, EMAX, EMIN, ONE, -ONE), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_COMPOSE, 2'd0, HALF, -HALF, TWO, 0), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_LOAD, 2'd1, EMAX, EMAX, EMIN, EMIN), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_COMPOSE, 2'd1, EMAX, EMAX, EMAX, EMAX), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_COMPOSE, 2'd1, EMIN, EMIN, EMAX, EMIN), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_COMPOSE, 2'd3, ONE, 0, 0, 32'sh0000_7fff), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_VECTOR, 2'd0, HALF, -HALF, 1, -1), 1'b0, '0);
    // Half times plus and minus one LSB lands on rounding ties.
    add_step(mk_cmd(mte_pkg::KIND_LOAD, 2'd0, HALF, HALF, 0, 0), 1'b0, '0);
    add_step(mk_cmd(mte_pkg::KIND_VECTOR, 2'd0, 1, -1, 3, 0), 1'b0, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[n]) begin
      send_cmd(directed_steps[n].c, directed_steps[n].has_want, directed_steps[n].want);
    end

    // Random scenes. Most are well-formed: whole matrix loads, compose
    // passes over rows 0 to 3 in order, and bursts of transforms. The rest
    // is noise with any kind and row. Some scenes run with no idling.
    while (cmds_sent < directed_steps.size() + RAND_ITEMS) begin
      no_idle = ($urandom_range(0, 9) < 2);
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        for (int i = 0; i < DIM; i++) begin
          send_rand(rand_cmd(mte_pkg::KIND_LOAD, ROW_W'(i), $urandom_range(0, 9) < 7));
        end
      end else if (pick < 40) begin
        for (int i = 0; i < DIM; i++) begin
          send_rand(rand_cmd(mte_pkg::KIND_COMPOSE, ROW_W'(i), $urandom_range(0, 9) < 8));
        end
      end else if (pick < 88) begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          send_rand(rand_cmd(($urandom_range(0, 1) != 0) ? mte_pkg::KIND_POINT
                                                         : mte_pkg::KIND_VECTOR,
                             ROW_W'($urandom_range(0, 3)), 1'b0));
        end
      end else begin
        burst = $urandom_range(1, 3);
        repeat (burst) begin
          send_rand(rand_cmd(mte_pkg::kind_t'($urandom_range(0, 3)),
                             ROW_W'($urandom_range(0, 3)), $urandom_range(0, 1) != 0));
        end
      end
    end

    // Drain: wait for every expected result, then keep the clock running
    // so that any stray result would still be caught.
    no_idle = 1'b0;
    cmd_valid <= 1'b0;
    while (pending_xforms.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run needs.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
